// ===== rtl/ffbs_pkg.sv =====
// Package with the item types and constants of the float and integer byte serializer.
package ffbs_pkg;

  typedef struct packed {
    logic        req_type;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [47:0] bytes;
    logic [2:0]  nbytes;
  } conv_t;

  localparam logic        REQ_FLOAT    = 1'b0;
  localparam logic        REQ_INT      = 1'b1;
  localparam logic [23:0] FX_MAX_INT   = 24'h7F_FFFF;
  localparam logic [23:0] FX_SIGN_BIT  = 24'h80_0000;
  localparam logic [23:0] FX_WORD_MAX  = 24'hFF_FFFF;
  localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0]  EXP_CLAMP    = 8'd150;
  localparam logic [7:0]  EXP_ZERO     = 8'd0;
  localparam logic [2:0]  FLOAT_BYTES  = 3'd6;
  localparam logic [2:0]  INT_BYTES    = 3'd3;

endpackage

// ===== rtl/ffbs_convert.sv =====
// Combinational conversion of one item into its big-endian result bytes.
module ffbs_convert import ffbs_pkg::*; (
  input  in_item_t item,
  output conv_t    conv
);

  logic        sign;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [23:0] sig;
  logic [7:0]  sh;
  logic [47:0] fixed;

  assign sign  = item.payload[31];
  assign ex    = item.payload[30:23];
  assign man   = item.payload[22:0];
  assign sig   = {1'b1, man};
  assign sh    = EXP_CLAMP - ex;
  assign fixed = (sh < 8'd64) ? ({sig, 24'h00_0000} >> sh[5:0]) : 48'h0;

  always_comb begin
    logic [23:0] ipart;
    logic [23:0] fpart;
    logic [23:0] iword;
    logic [23:0] wsat;
    logic        nonzero;
    ipart   = 24'h0;
    fpart   = 24'h0;
    nonzero = 1'b0;
    wsat    = (item.payload[31:24] != 8'h00) ? FX_WORD_MAX : item.payload[23:0];
    priority if (ex == EXP_ALL_ONES && man != 23'h0) begin
      nonzero = 1'b0;
    end else if (ex == EXP_ALL_ONES || ex >= EXP_CLAMP) begin
      ipart   = FX_MAX_INT;
      nonzero = 1'b1;
    end else if (ex == EXP_ZERO) begin
      nonzero = (man != 23'h0);
    end else begin
      nonzero = 1'b1;
      if (fixed[47:24] == FX_MAX_INT && fixed[23:0] != 24'h0) begin
        ipart = FX_MAX_INT;
      end else begin
        ipart = fixed[47:24];
        fpart = fixed[23:0];
      end
    end
    iword = (sign && nonzero) ? (ipart | FX_SIGN_BIT) : ipart;
    if (item.req_type == REQ_INT) begin
      conv.bytes  = {wsat, 24'h00_0000};
      conv.nbytes = INT_BYTES;
    end else begin
      conv.bytes  = {iword, fpart};
      conv.nbytes = FLOAT_BYTES;
    end
  end

endmodule

// ===== rtl/float_fixed_byte_serializer.sv =====
// Top level of the float and integer byte serializer.
// Each item is a float32 pattern, sent as six bytes of sign-magnitude 24.24 fixed point, or an
// unsigned integer, sent saturated as three bytes; bytes go out most significant first, one per
// cycle on result, each marked by strobe for one cycle, with last_byte on the final one. The
// receiver cannot stall. Items stream with no gap between them. One item waits in the input
// register while the previous one is serialized, and busy is high while that register is full
// and the serializer still has bytes to send. From an idle block an accepted item goes into the
// input register, and its first byte is then registered into result from the conversion.
module float_fixed_byte_serializer import ffbs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  req,
  output logic      strobe,
  output out_item_t result
);

  logic        in_valid;
  in_item_t    in_item;
  conv_t       conv;
  logic [39:0] rem_sr;
  logic [2:0]  rem_cnt;
  logic        accept;
  logic        advance;

  ffbs_convert u_convert (
    .item(in_item),
    .conv(conv)
  );

  assign busy    = in_valid && (rem_cnt != 3'd0);
  assign accept  = start && !busy;
  assign advance = in_valid && (rem_cnt == 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rem_cnt  <= 3'd0;
      strobe   <= 1'b0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (rem_cnt != 3'd0) begin
        rem_cnt <= rem_cnt - 3'd1;
        strobe  <= 1'b1;
      end else if (advance) begin
        rem_cnt <= conv.nbytes - 3'd1;
        strobe  <= 1'b1;
      end else begin
        strobe  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= req;
    end
    if (rem_cnt != 3'd0) begin
      result.out_byte  <= rem_sr[39:32];
      result.last_byte <= (rem_cnt == 3'd1);
      rem_sr           <= {rem_sr[31:0], 8'h00};
    end else if (advance) begin
      result.out_byte  <= conv.bytes[47:40];
      result.last_byte <= (conv.nbytes == 3'd1);
      rem_sr           <= conv.bytes[39:0];
    end
  end

endmodule

// ===== rtl/ffbs_checker.sv =====
// Port-level assertions for the float and integer byte serializer, with its bind statement.
module ffbs_checker import ffbs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input in_item_t  req,
  input logic      strobe,
  input out_item_t result
);

  logic unused_ok;
  assign unused_ok = start ^ (^req);

  a_reset_quiet: assert property (@(posedge clk) rst |=> (!strobe && !busy))
    else $error("strobe or busy high after reset");

  a_busy_sends: assert property (@(posedge clk) disable iff (rst) busy |=> strobe)
    else $error("busy without a byte being sent");

  a_item_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_byte) |=> strobe)
    else $error("gap inside the bytes of one item");

  a_last_spacing: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_byte) |=> !(strobe && result.last_byte))
    else $error("two final bytes in a row");

endmodule

bind float_fixed_byte_serializer ffbs_checker u_ffbs_checker (.*);
